[rtl/core/lrwst_pkg.sv]
// Shared types and constants for the lane row width section tagger.
// Used by the history cell, the top level and the port checker.
package lrwst_pkg;

  // row tags
  localparam logic [1:0] TAG_OK      = 2'd0;
  localparam logic [1:0] TAG_SUSPECT = 2'd1;
  localparam logic [1:0] TAG_ERR     = 2'd2;

  // configuration register indexes
  localparam int CFG_IDX_BITS = 3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_HALF_HEIGHT    = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_NEAR_MIN_WIDTH = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_NEAR_MAX_WIDTH = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_FAR_MIN_WIDTH  = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_FAR_MAX_WIDTH  = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_WIDTH_STEP = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] CFG_HOP_LIMIT      = 3'd6;

  localparam int CFG_BITS = 10;
  localparam int HOP_BITS = 4;
  // counters reach hop_limit + 1
  localparam int CNT_BITS = HOP_BITS + 1;

  localparam logic [CFG_BITS-1:0] HALF_HEIGHT_RST    = 10'd120;
  localparam logic [CFG_BITS-1:0] NEAR_MIN_WIDTH_RST = 10'd20;
  localparam logic [CFG_BITS-1:0] NEAR_MAX_WIDTH_RST = 10'd40;
  localparam logic [CFG_BITS-1:0] FAR_MIN_WIDTH_RST  = 10'd12;
  localparam logic [CFG_BITS-1:0] FAR_MAX_WIDTH_RST  = 10'd30;
  localparam logic [CFG_BITS-1:0] MAX_WIDTH_STEP_RST = 10'd7;
  localparam logic [HOP_BITS-1:0] HOP_LIMIT_RST      = 4'd4;

  // wide enough for an age of up to 32 history rows
  localparam int SRCH_AGE_BITS = 6;

  typedef enum logic [2:0] {
    MODE_IDLE = 3'b001,
    MODE_ERR  = 3'b010,
    MODE_COR  = 3'b100
  } mode_t;

  // oldest-correct search link, passed from older cells to newer ones
  typedef struct packed {
    logic                     found;
    logic [SRCH_AGE_BITS-1:0] age;
  } srch_t;

  typedef struct packed {
    logic [1:0] tag;
    logic       start;
    logic       kind;
  } result_t;

endpackage

[rtl/core/lane_row_width_section_tagger_unit.sv]
// Top level of the lane row width section tagger: section control,
// configuration registers, history cell chain and output queue.
// Depends on lrwst_pkg and lrwst_cell.
//
// Usage:
//   Rows of a lane blob arrive in order on the input channel (in_valid /
//   in_ready) with row_position, run_width and first_row; first_row closes
//   any open section. Each row yields exactly one result on the output
//   channel (out_valid / out_ready): row_tag, section_start, section_kind.
//   The result of an accepted row is registered into the output queue.
//   Throughput: one row per cycle while in_ready is high; the whole
//   section decision, the reference read from the history chain and the
//   oldest-correct search through the chain settle in the accepting cycle.
//   A two-entry output queue holds results while the receiver stalls;
//   in_ready drops only when both entries are full.
//   Reset (rst, synchronous): no section open, counters cleared, history
//   widths zero with all tags error, registers at their defaults, queue
//   empty. Configuration writes (cfg_we, cfg_index, cfg_data) take effect
//   at the clock edge and must only happen while the block is idle.
module lane_row_width_section_tagger_unit #(
  parameter int LOOKBACK_ROWS = 10,
  parameter int COORD_BITS    = 10
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [lrwst_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [lrwst_pkg::CFG_BITS-1:0]     cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [COORD_BITS-1:0]              row_position,
  input  logic [COORD_BITS-1:0]              run_width,
  input  logic                               first_row,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [1:0]                         row_tag,
  output logic                               section_start,
  output logic                               section_kind
);
  import lrwst_pkg::*;

  localparam int IDX_BITS = $clog2(LOOKBACK_ROWS);
  localparam int AGE_BITS = $clog2(LOOKBACK_ROWS + 1);
  localparam int CMP_BITS = (COORD_BITS > CFG_BITS) ? COORD_BITS : CFG_BITS;

  // configuration
  logic [CFG_BITS-1:0] half_height, near_min_width, near_max_width;
  logic [CFG_BITS-1:0] far_min_width, far_max_width, max_width_step;
  logic [HOP_BITS-1:0] hop_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_height    <= HALF_HEIGHT_RST;
      near_min_width <= NEAR_MIN_WIDTH_RST;
      near_max_width <= NEAR_MAX_WIDTH_RST;
      far_min_width  <= FAR_MIN_WIDTH_RST;
      far_max_width  <= FAR_MAX_WIDTH_RST;
      max_width_step <= MAX_WIDTH_STEP_RST;
      hop_limit      <= HOP_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_HALF_HEIGHT:    half_height    <= cfg_data;
        CFG_NEAR_MIN_WIDTH: near_min_width <= cfg_data;
        CFG_NEAR_MAX_WIDTH: near_max_width <= cfg_data;
        CFG_FAR_MIN_WIDTH:  far_min_width  <= cfg_data;
        CFG_FAR_MAX_WIDTH:  far_max_width  <= cfg_data;
        CFG_MAX_WIDTH_STEP: max_width_step <= cfg_data;
        CFG_HOP_LIMIT:      hop_limit      <= cfg_data[HOP_BITS-1:0];
        default: ;
      endcase
    end
  end

  // section state
  mode_t                 mode, mode_next;
  logic [CNT_BITS-1:0]   stable_count, stable_count_next;
  logic [COORD_BITS-1:0] stable_ref, stable_ref_next;
  logic [CNT_BITS-1:0]   fail_count, fail_count_next;
  logic [AGE_BITS-1:0]   ref_age, ref_age_next;

  logic accept;
  assign accept = in_valid && in_ready;

  // history chain
  logic [COORD_BITS-1:0] hist_w   [LOOKBACK_ROWS];
  logic [1:0]            hist_tag [LOOKBACK_ROWS];
  logic [COORD_BITS-1:0] rd_link  [LOOKBACK_ROWS+1];
  srch_t                 srch_link [LOOKBACK_ROWS+1];
  logic [IDX_BITS-1:0]   rd_idx;
  logic [1:0]            tag;

  assign rd_idx                   = IDX_BITS'(ref_age - 1'b1);
  assign rd_link[0]               = '0;
  assign srch_link[LOOKBACK_ROWS] = '0;

  for (genvar i = 0; i < LOOKBACK_ROWS; i++) begin : g_cell
    lrwst_cell #(
      .POS       (i),
      .COORD_BITS(COORD_BITS),
      .IDX_BITS  (IDX_BITS)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .shift   (accept),
      .d_width ((i == 0) ? run_width : hist_w[(i == 0) ? 0 : i-1]),
      .d_tag   ((i == 0) ? tag : hist_tag[(i == 0) ? 0 : i-1]),
      .q_width (hist_w[i]),
      .q_tag   (hist_tag[i]),
      .rd_idx  (rd_idx),
      .rd_in   (rd_link[i]),
      .rd_out  (rd_link[i+1]),
      .srch_in (srch_link[i+1]),
      .srch_out(srch_link[i])
    );
  end

  // row classification
  logic [CMP_BITS-1:0]   wx, px, step_x;
  logic                  band, consistent, stable_ok, narrow;
  logic [COORD_BITS-1:0] ref_w, diff_ref, diff_stable;
  logic [CNT_BITS-1:0]   hop_x;
  mode_t                 mode_in;

  assign wx     = CMP_BITS'(run_width);
  assign px     = CMP_BITS'(row_position);
  assign step_x = CMP_BITS'(max_width_step);
  assign hop_x  = CNT_BITS'(hop_limit);
  assign narrow = wx < CMP_BITS'(near_min_width);

  assign band = (px >= CMP_BITS'(half_height)) ?
                (wx >= CMP_BITS'(near_min_width) && wx <= CMP_BITS'(near_max_width)) :
                (wx >= CMP_BITS'(far_min_width) && wx <= CMP_BITS'(far_max_width));

  assign ref_w       = (ref_age == '0) ? run_width : rd_link[LOOKBACK_ROWS];
  assign diff_ref    = (run_width > ref_w) ? run_width - ref_w : ref_w - run_width;
  assign diff_stable = (run_width > stable_ref) ? run_width - stable_ref
                                                : stable_ref - run_width;
  assign consistent  = CMP_BITS'(diff_ref) < step_x;
  assign stable_ok   = CMP_BITS'(diff_stable) < step_x;
  assign mode_in     = first_row ? MODE_IDLE : mode;

  logic                start, kind;
  logic                fresh_cor, fresh_err;
  mode_t               mode_sel;
  logic [AGE_BITS-1:0] age_sel;
  logic [AGE_BITS:0]   age_inc;

  always_comb begin
    start             = 1'b0;
    kind              = 1'b1;
    tag               = TAG_ERR;
    fresh_cor         = 1'b0;
    fresh_err         = 1'b0;
    mode_sel          = mode_in;
    stable_count_next = stable_count;
    stable_ref_next   = stable_ref;
    fail_count_next   = fail_count;
    age_sel           = ref_age;

    unique case (mode_in)
      MODE_ERR: begin
        if (band) begin
          if (stable_count == '0) begin
            stable_ref_next   = run_width;
            stable_count_next = CNT_BITS'(1);
          end else if (stable_count > hop_x) begin
            start     = 1'b1;
            fresh_cor = 1'b1;
          end else if (stable_ok) begin
            stable_count_next = stable_count + 1'b1;
          end else begin
            stable_count_next = '0;
          end
        end
      end
      MODE_COR: begin
        kind = 1'b0;
        if (consistent) begin
          tag             = TAG_OK;
          fail_count_next = '0;
        end else if (narrow) begin
          tag             = TAG_SUSPECT;
          fail_count_next = '0;
        end else if (fail_count <= hop_x) begin
          tag             = TAG_SUSPECT;
          fail_count_next = fail_count + 1'b1;
        end else begin
          // section ends; the row opens a new one
          start     = 1'b1;
          fresh_cor = band;
          fresh_err = !band;
        end
      end
      default: begin
        start     = 1'b1;
        fresh_cor = band;
        fresh_err = !band;
      end
    endcase

    // a freshly opened correct section compares the row with itself
    if (fresh_cor) begin
      mode_sel = MODE_COR;
      kind     = 1'b0;
      age_sel  = '0;
      if (max_width_step != '0) begin
        tag             = TAG_OK;
        fail_count_next = '0;
      end else begin
        tag             = TAG_SUSPECT;
        fail_count_next = narrow ? CNT_BITS'(0) : CNT_BITS'(1);
      end
    end
    if (fresh_err) begin
      mode_sel          = MODE_ERR;
      kind              = 1'b1;
      tag               = TAG_ERR;
      stable_count_next = '0;
      stable_ref_next   = '0;
    end

    // reference refresh after the history push
    mode_next    = mode_sel;
    ref_age_next = age_sel;
    age_inc      = {1'b0, age_sel} + 1'b1;
    if (mode_sel == MODE_COR) begin
      if (age_inc > (AGE_BITS+1)'(LOOKBACK_ROWS)) begin
        if (srch_link[0].found) begin
          ref_age_next = AGE_BITS'(srch_link[0].age);
        end else begin
          mode_next    = MODE_IDLE;
          ref_age_next = '0;
        end
      end else begin
        ref_age_next = age_inc[AGE_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_IDLE;
      stable_count <= '0;
      stable_ref   <= '0;
      fail_count   <= '0;
      ref_age      <= '0;
    end else if (accept) begin
      mode         <= mode_next;
      stable_count <= stable_count_next;
      stable_ref   <= stable_ref_next;
      fail_count   <= fail_count_next;
      ref_age      <= ref_age_next;
    end
  end

  // two-entry output queue
  result_t res, q0, q1;
  logic    q0_valid, q1_valid, pop;

  assign res.tag   = tag;
  assign res.start = start;
  assign res.kind  = kind;
  assign pop       = q0_valid && out_ready;
  assign in_ready  = !q1_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      q0_valid <= 1'b0;
      q1_valid <= 1'b0;
    end else if (!q0_valid || pop) begin
      if (q1_valid) begin
        q0_valid <= 1'b1;
        q1_valid <= 1'b0;
      end else begin
        q0_valid <= accept;
      end
    end else if (accept) begin
      q1_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!q0_valid || pop) begin
      q0 <= q1_valid ? q1 : res;
    end
    if (q0_valid && !pop && accept) begin
      q1 <= res;
    end
  end

  assign out_valid     = q0_valid;
  assign row_tag       = q0.tag;
  assign section_start = q0.start;
  assign section_kind  = q0.kind;

endmodule

[rtl/core/lrwst_cell.sv]
// One history cell: holds a row width and tag, shifts them to the older
// neighbor, and takes part in the reference read and oldest-correct chains.
// Depends on lrwst_pkg.
module lrwst_cell #(
  parameter int POS        = 0,
  parameter int COORD_BITS = 10,
  parameter int IDX_BITS   = 4
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   shift,
  input  logic [COORD_BITS-1:0]  d_width,
  input  logic [1:0]             d_tag,
  output logic [COORD_BITS-1:0]  q_width,
  output logic [1:0]             q_tag,
  input  logic [IDX_BITS-1:0]    rd_idx,
  input  logic [COORD_BITS-1:0]  rd_in,
  output logic [COORD_BITS-1:0]  rd_out,
  input  lrwst_pkg::srch_t       srch_in,
  output lrwst_pkg::srch_t       srch_out
);
  import lrwst_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_width <= '0;
      q_tag   <= TAG_ERR;
    end else if (shift) begin
      q_width <= d_width;
      q_tag   <= d_tag;
    end
  end

  assign rd_out = rd_in | ((rd_idx == IDX_BITS'(POS)) ? q_width : '0);

  // d_tag is what this cell holds after the shift; an older hit wins
  assign srch_out.found = srch_in.found | (d_tag == TAG_OK);
  assign srch_out.age   = srch_in.found ? srch_in.age : SRCH_AGE_BITS'(POS + 1);

endmodule

[rtl/core/lrwst_checker.sv]
// Port-level checks for the lane row width section tagger, bound to the
// top level. Depends on lrwst_pkg.
module lrwst_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] row_tag,
  input logic       section_start,
  input logic       section_kind
);
  import lrwst_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(row_tag) &&
      $stable(section_start) && $stable(section_kind))
    else $error("stalled result changed");

  a_tag_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (row_tag == TAG_OK || row_tag == TAG_SUSPECT || row_tag == TAG_ERR))
    else $error("row_tag out of range");

  // error rows live in error sections, the rest in correct sections
  a_kind_tag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (section_kind == (row_tag == TAG_ERR)))
    else $error("section_kind disagrees with row_tag");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("queue not empty after reset");

endmodule

bind lane_row_width_section_tagger_unit lrwst_checker u_lrwst_checker (.*);
